// ----- sv/chs_pkg.sv -----
// Package for the chained hash set: shared widths, command and register
// codes, and the item word passed from the front end to the back end.
// No dependencies.
package chs_pkg;

  // Key and configuration widths.
  localparam int KEY_W = 32;
  localparam int REM_W = 5;
  localparam int CNT_W = $clog2(KEY_W);

  // Default sizes of the bucket store.
  localparam int NUM_BUCKETS_DFLT  = 16;
  localparam int BUCKET_DEPTH_DFLT = 8;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [REM_W-1:0] BUCKET_COUNT_RST = 5'd10;

  // Register indexes (word address).
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Queue between front end and back end.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // One classified word: command, key, and its bucket index.
  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [REM_W-1:0] bucket;
  } chs_item_t;

endpackage

// ----- sv/chained_hash_set_unit.sv -----
// Top level of the chained hash set: configuration registers, front end,
// queue and back end. Depends on chs_pkg, chs_front, chs_queue, chs_back.
//
//   Port group   Direction   Handshake          Payload
//   in_          to block    in_valid/in_stall   in_cmd, in_key
//   out_         from block  out_valid/out_stall out_found, out_bucket_full
//   APB          to block    psel/penable/pready bucket_count at address 0
//
// The front end takes one word at a time: it accepts it, finds the
// bit-serial remainder of the key by the bucket count, and queues it.
// The back end reads the fill count for an insert, and for a query also
// walks the chain, one chain entry per key memory read, so it keeps up.
// After reset the fill counts are cleared, one bucket a cycle, over all
// NUM_BUCKETS buckets; in_stall stays high during that pass.
// A stalled result does not hold up the front end until the queue fills.
module chained_hash_set_unit #(
  parameter int NUM_BUCKETS  = chs_pkg::NUM_BUCKETS_DFLT,
  parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [chs_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic                          out_bucket_full,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chs_pkg::PADDR_W-1:0]   paddr,
  input  logic [chs_pkg::PDATA_W-1:0]   pwdata,
  output logic [chs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [chs_pkg::REM_W-1:0] bucket_count_r, bucket_count_nxt;
  logic                      reg_sel;
  logic                      q_push, q_full, q_pop, q_empty;
  logic                      clearing;
  chs_pkg::chs_item_t        push_item, pop_item;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    bucket_count_nxt = bucket_count_r;
    if (psel && penable && pwrite && (reg_sel == chs_pkg::REG_BUCKET_COUNT)) begin
      bucket_count_nxt = pwdata[chs_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= chs_pkg::BUCKET_COUNT_RST;
    end else begin
      bucket_count_r <= bucket_count_nxt;
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    if (reg_sel == chs_pkg::REG_BUCKET_COUNT) begin
      prdata = chs_pkg::PDATA_W'(bucket_count_r);
    end
  end

  // Front end: accept and find the bucket.
  chs_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_key       (in_key),
    .bucket_count (bucket_count_r),
    .hold         (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // Queue between the two halves.
  chs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // Back end: chain memories and the result word.
  chs_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_bucket_full (out_bucket_full)
  );

endmodule

// ----- sv/chs_front.sv -----
// Front end of the chained hash set: accepts words and finds the bucket
// with a bit-serial remainder unit, then pushes the word into the queue.
// Depends on chs_pkg.
module chs_front #(
  parameter int NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DFLT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [chs_pkg::KEY_W-1:0]       in_key,
  input  logic [chs_pkg::REM_W-1:0]       bucket_count,
  input  logic                            hold,
  input  logic                            q_full,
  output logic                            q_push,
  output chs_pkg::chs_item_t              q_item
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t                    state_r, state_nxt;
  logic                            cmd_r, cmd_nxt;
  logic [chs_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [chs_pkg::KEY_W-1:0]       sh_r, sh_nxt;
  logic [chs_pkg::REM_W-1:0]       div_r, div_nxt;
  logic [chs_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [chs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [chs_pkg::REM_W-1:0]       active;
  logic [chs_pkg::REM_W:0]         trial;
  logic [chs_pkg::REM_W:0]         diff;
  logic                            accept;

  // Bucket count in use: zero acts as one, and it never exceeds the store.
  always_comb begin
    if (bucket_count == '0) begin
      active = chs_pkg::REM_W'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      active = chs_pkg::REM_W'(NUM_BUCKETS);
    end else begin
      active = bucket_count;
    end
  end

  assign in_stall = (state_r != F_IDLE) || hold;
  assign accept   = in_valid && !in_stall;

  // One restoring remainder step: shift in the next key bit, subtract if it fits.
  assign trial = {rem_r, sh_r[chs_pkg::KEY_W-1]};
  assign diff  = trial - {1'b0, div_r};

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    sh_nxt    = sh_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key;
          sh_nxt    = in_key;
          div_nxt   = active;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = diff[chs_pkg::REM_W-1:0];
        end else begin
          rem_nxt = trial[chs_pkg::REM_W-1:0];
        end
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == chs_pkg::CNT_W'(chs_pkg::KEY_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign q_item = '{cmd: cmd_r, key: key_r, bucket: rem_r};

  // A finished remainder is always below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> (rem_r < div_r))
    else $error("bucket index not below bucket count");

endmodule

// ----- sv/chs_queue.sv -----
// Short queue between the front end and the back end of the hash set.
// Holds classified words so each side can stall on its own.
// Depends on chs_pkg.
module chs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  chs_pkg::chs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output chs_pkg::chs_item_t pop_item,
  output logic               empty
);

  chs_pkg::chs_item_t               entries_r [chs_pkg::Q_DEPTH];
  logic [chs_pkg::QP_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [chs_pkg::QP_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [chs_pkg::QC_W-1:0]         count_r, count_nxt;

  assign full     = (count_r == chs_pkg::QC_W'(chs_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = entries_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ----- sv/chs_back.sv -----
// Back end of the hash set: bucket fill memory and chain key memory.
// Appends keys on insert, walks the chain on query, and holds the result word.
// Depends on chs_pkg.
module chs_back #(
  parameter int NUM_BUCKETS  = chs_pkg::NUM_BUCKETS_DFLT,
  parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  chs_pkg::chs_item_t q_item,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic               out_bucket_full
);

  localparam int MEM_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int BW        = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int FW        = $clog2(BUCKET_DEPTH + 1);

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_FILL  = 4'b0100,
    B_WALK  = 4'b1000
  } back_state_t;

  back_state_t                 state_r, state_nxt;
  logic [BW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic                        cmd_r, cmd_nxt;
  logic [chs_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [BW-1:0]               bidx_r, bidx_nxt;
  logic [AW-1:0]               base_r, base_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic [FW-1:0]               slot_r, slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        found_r, found_nxt;
  logic                        full_r, full_nxt;

  logic [BW+chs_pkg::REM_W-1:0] bucket_ext;
  logic [BW-1:0]               q_bidx;
  logic [FW-1:0]               slot_next;

  // Memory ports.
  logic [chs_pkg::KEY_W-1:0]   key_mem [MEM_DEPTH];
  logic [FW-1:0]               fill_mem [NUM_BUCKETS];
  logic [chs_pkg::KEY_W-1:0]   key_rd_q;
  logic [FW-1:0]               fill_rd_q;
  logic [AW-1:0]               key_rd_addr;
  logic                        key_we;
  logic [AW-1:0]               key_wr_addr;
  logic                        fill_we;
  logic [BW-1:0]               fill_wr_addr;
  logic [FW-1:0]               fill_wr_data;

  // Bucket index of the queue head, zero-extended, then cut to the store's index width.
  assign bucket_ext = {{BW{1'b0}}, q_item.bucket};
  assign q_bidx     = bucket_ext[BW-1:0];

  assign slot_next   = slot_r + 1'b1;
  assign key_rd_addr = base_r + ((state_r == B_WALK) ? AW'(slot_next) : '0);

  assign clearing = (state_r == B_CLEAR);
  assign q_pop    = (state_r == B_IDLE) && !q_empty && (!out_valid_r || !out_stall);

  // Sequencer: clear the fill counts, then one word at a time.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    bidx_nxt      = bidx_r;
    base_nxt      = base_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    found_nxt     = found_r;
    full_nxt      = full_r;
    key_we        = 1'b0;
    key_wr_addr   = base_r + AW'(fill_rd_q);
    fill_we       = 1'b0;
    fill_wr_addr  = bidx_r;
    fill_wr_data  = fill_rd_q + 1'b1;
    case (state_r)
      B_CLEAR: begin
        fill_we      = 1'b1;
        fill_wr_addr = clr_cnt_r;
        fill_wr_data = '0;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_pop) begin
          cmd_nxt   = q_item.cmd;
          key_nxt   = q_item.key;
          bidx_nxt  = q_bidx;
          base_nxt  = AW'(32'(q_bidx) * BUCKET_DEPTH);
          state_nxt = B_FILL;
        end
      end
      B_FILL: begin
        fill_nxt = fill_rd_q;
        slot_nxt = '0;
        if (cmd_r == chs_pkg::CMD_INSERT) begin
          // Append unless the chain is already full.
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          state_nxt     = B_IDLE;
          if (fill_rd_q >= FW'(BUCKET_DEPTH)) begin
            full_nxt = 1'b1;
          end else begin
            full_nxt = 1'b0;
            key_we   = 1'b1;
            fill_we  = 1'b1;
          end
        end else if (fill_rd_q == '0) begin
          // Query of an empty chain.
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          full_nxt      = 1'b0;
          state_nxt     = B_IDLE;
        end else begin
          state_nxt = B_WALK;
        end
      end
      B_WALK: begin
        // Compare one chain entry a cycle; the next read is already issued.
        if ((key_rd_q == key_r) || (slot_next == fill_r)) begin
          out_valid_nxt = 1'b1;
          found_nxt     = (key_rd_q == key_r);
          full_nxt      = 1'b0;
          state_nxt     = B_IDLE;
        end else begin
          slot_nxt = slot_next;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    bidx_r  <= bidx_nxt;
    base_r  <= base_nxt;
    fill_r  <= fill_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
    full_r  <= full_nxt;
  end

  // Chain key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wr_addr] <= key_r;
    end
    key_rd_q <= key_mem[key_rd_addr];
  end

  // Fill count memory, read at the queue head's bucket.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wr_addr] <= fill_wr_data;
    end
    fill_rd_q <= fill_mem[q_bidx];
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_bucket_full = full_r;

  a_walk_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK) |-> (slot_r < fill_r))
    else $error("chain walk past the fill count");

  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> (fill_rd_q < FW'(BUCKET_DEPTH)) && fill_we)
    else $error("append into a full chain");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == B_FILL || $past(state_r) == B_WALK))
    else $error("result word raised outside an operation");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for chained_hash_set_unit: sends insert and query words with random idling,
// predicts the found and bucket-full flags from its own copy of the chains, and checks
// every result word in order. Depends on chs_pkg and the RTL of the block.
module testbench;

  localparam int NB          = chs_pkg::NUM_BUCKETS_DFLT;
  localparam int DEPTH       = chs_pkg::BUCKET_DEPTH_DFLT;
  localparam int MAX_REPORTS = 20;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic found;
    logic full;
  } set_reply_t;

  // Block ports, all inputs known from time zero.
  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_cmd   = chs_pkg::CMD_INSERT;
  logic [chs_pkg::KEY_W-1:0]   in_key   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_found;
  logic                        out_bucket_full;
  logic                        psel     = 1'b0;
  logic                        penable  = 1'b0;
  logic                        pwrite   = 1'b0;
  logic [chs_pkg::PADDR_W-1:0] paddr    = '0;
  logic [chs_pkg::PDATA_W-1:0] pwdata   = '0;
  logic [chs_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  // Shadow copy of the chains and of the bucket count register.
  logic [chs_pkg::KEY_W-1:0] chain_key [NB][DEPTH];
  int unsigned               chain_len [NB] = '{default: 0};
  logic [chs_pkg::REM_W-1:0] bucket_count_reg = chs_pkg::BUCKET_COUNT_RST;

  set_reply_t                reply_q[$];
  logic [chs_pkg::KEY_W-1:0] inserted_keys[$];
  int                        error_count = 0;
  int                        sender_idle_pct = 0;
  int                        receiver_idle_pct = 0;
  int                        hold_req = 0;
  int                        hold_seen = 0;
  int                        hold_cycles = 0;
  int                        stall_run = 0;

  chained_hash_set_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_bucket_full (out_bucket_full),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial forever #2 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [chs_pkg::KEY_W-1:0] want,
                                 input logic [chs_pkg::KEY_W-1:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // A count of zero acts as one bucket, and counts above the store saturate.
  function automatic int unsigned buckets_in_use();
    if (bucket_count_reg == 0) return 1;
    if (bucket_count_reg > NB) return NB;
    return bucket_count_reg;
  endfunction

  // Apply one word to the shadow chains and return the flags it should produce.
  function automatic set_reply_t apply_word(input logic cmd,
                                            input logic [chs_pkg::KEY_W-1:0] key);
    set_reply_t  r;
    int unsigned b;
    int unsigned i;
    r = '0;
    b = key % buckets_in_use();
    if (cmd == chs_pkg::CMD_QUERY) begin
      for (i = 0; i < chain_len[b]; i++) begin
        if (chain_key[b][i] == key) r.found = 1'b1;
      end
    end else if (chain_len[b] >= DEPTH) begin
      r.full = 1'b1;
    end else begin
      chain_key[b][chain_len[b]] = key;
      chain_len[b]++;
    end
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  // Offer one word and wait until the block takes it. Valid stays high on return.
  task automatic send_word(input logic cmd, input logic [chs_pkg::KEY_W-1:0] key);
    int gap;
    gap = pick_gap(sender_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    reply_q.push_back(apply_word(cmd, key));
    if (cmd == chs_pkg::CMD_INSERT) inserted_keys.push_back(key);
  endtask

  // Stop offering and wait until every predicted result word has been seen.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  // Write the bucket count with the block idle, then read it back.
  task automatic write_bucket_count(input logic [chs_pkg::REM_W-1:0] value);
    logic [chs_pkg::PDATA_W-1:0] readback;
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= chs_pkg::PADDR_W'(4 * chs_pkg::REG_BUCKET_COUNT);
    pwdata  <= chs_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    bucket_count_reg = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[chs_pkg::REM_W-1:0] !== value) begin
      report_mismatch("bucket_count readback", chs_pkg::KEY_W'(value),
                      chs_pkg::KEY_W'(readback[chs_pkg::REM_W-1:0]));
    end
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    set_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        report_mismatch("result word with none pending", 0, 1);
      end else begin
        want = reply_q.pop_front();
        if (out_found !== want.found) begin
          report_mismatch("found", chs_pkg::KEY_W'(want.found), chs_pkg::KEY_W'(out_found));
        end
        if (out_bucket_full !== want.full) begin
          report_mismatch("bucket_full", chs_pkg::KEY_W'(want.full),
                          chs_pkg::KEY_W'(out_bucket_full));
        end
      end
    end
  end

  // Result side stall: a requested long hold first, then random runs.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_cycles = LONG_HOLD;
      hold_seen   = hold_req;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < receiver_idle_pct) begin
      stall_run = ($urandom_range(9) == 0) ? $urandom_range(50, 15) : $urandom_range(2, 0);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Reset count of ten: extremes of the key, hits, misses and a duplicate.
  task automatic test_default_count();
    send_word(chs_pkg::CMD_INSERT, 32'h0000_0000);
    send_word(chs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_word(chs_pkg::CMD_QUERY,  32'h0000_0000);
    send_word(chs_pkg::CMD_QUERY,  32'hFFFF_FFFF);
    send_word(chs_pkg::CMD_QUERY,  32'd10);
    send_word(chs_pkg::CMD_QUERY,  32'h8000_0000);
    send_word(chs_pkg::CMD_INSERT, 32'h0000_0000);
  endtask

  // A count of zero sends every key to one chain; fill it and overflow it.
  task automatic test_chain_overflow();
    write_bucket_count(5'd0);
    for (int k = 1; k <= 6; k++) send_word(chs_pkg::CMD_INSERT, chs_pkg::KEY_W'(k));
    send_word(chs_pkg::CMD_INSERT, 32'd7);
    send_word(chs_pkg::CMD_QUERY,  32'd6);
    send_word(chs_pkg::CMD_QUERY,  32'd7);
  endtask

  // The largest count saturates to the size of the store.
  task automatic test_count_saturation();
    write_bucket_count(5'd31);
    send_word(chs_pkg::CMD_INSERT, 32'h5555_5555);
    send_word(chs_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_word(chs_pkg::CMD_QUERY,  32'h5555_5555);
    send_word(chs_pkg::CMD_QUERY,  32'h5555_5565);
  endtask

  // Changing the count leaves stored keys behind, so lookups may now miss them.
  task automatic test_rehash_miss();
    write_bucket_count(5'd7);
    send_word(chs_pkg::CMD_QUERY, 32'hAAAA_AAAA);
    send_word(chs_pkg::CMD_QUERY, 32'hFFFF_FFFF);
  endtask

  // Hold the result side long enough that the block stalls its input.
  task automatic test_backpressure();
    write_bucket_count(5'd16);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_req++;
    for (int k = 0; k < 10; k++) begin
      send_word(k % 2 ? chs_pkg::CMD_QUERY : chs_pkg::CMD_INSERT, $urandom);
    end
    wait_for_results();
  endtask

  // Random words, biased toward keys already stored and keys sharing their bucket.
  task automatic test_random_mix(input logic [chs_pkg::REM_W-1:0] count, input int words,
                                 input int query_pct, input int idle_pct);
    logic                      cmd;
    logic [chs_pkg::KEY_W-1:0] key;
    int                        pick;
    write_bucket_count(count);
    sender_idle_pct   = idle_pct;
    receiver_idle_pct = idle_pct;
    repeat (words) begin
      cmd  = ($urandom_range(99) < query_pct) ? chs_pkg::CMD_QUERY : chs_pkg::CMD_INSERT;
      pick = $urandom_range(99);
      if (pick < 35 && inserted_keys.size() > 0) begin
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      end else if (pick < 50 && inserted_keys.size() > 0) begin
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)]
              + chs_pkg::KEY_W'($urandom_range(3, 1) * buckets_in_use());
      end else if (pick < 62) begin
        key = chs_pkg::KEY_W'($urandom_range(40));
      end else if (pick < 72) begin
        key = {chs_pkg::KEY_W{1'b1}} - chs_pkg::KEY_W'($urandom_range(40));
      end else begin
        key = $urandom;
      end
      send_word(cmd, key);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct   = 30;
    receiver_idle_pct = 30;
    test_default_count();
    test_chain_overflow();
    test_count_saturation();
    test_rehash_miss();
    test_backpressure();
    test_random_mix(5'd16, 150, 60, 30);
    test_random_mix(5'd13,  60, 60, 0);
    test_random_mix(5'd1,   30, 70, 40);
    test_random_mix(5'd31, 100, 65, 30);
    test_random_mix(5'd17,  30, 60, 50);
    test_random_mix(5'd3,   30, 60, 20);
    wait_for_results();
    repeat (40) @(posedge clk);
    if (error_count == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
